[hw/rtl/wav_pcm_stream_parser_macros.svh]
// assertion macros for the wav pcm stream parser
// used by the files that carry concurrent checks
`ifndef WAV_PCM_STREAM_PARSER_MACROS_SVH
`define WAV_PCM_STREAM_PARSER_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define WPS_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication checked outside reset
`define WPS_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[hw/rtl/wps_pkg.sv]
// types and constants for the wav pcm stream parser
// no dependencies
`timescale 1ns / 1ps
package wps_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic [2:0]         error_code;
      logic               channel;
      logic signed [15:0] sample_value;
      logic               last_frame;
      logic [1:0]         out_channels;
      logic [4:0]         sample_bits;
      logic [31:0]        fmt_rate;
      logic [31:0]        frame_count;
   } rsp_item_type;

   typedef enum logic [6:0] {
      PH_HEAD    = 7'b0000001,
      PH_LSIZE   = 7'b0000010,
      PH_LSKIP   = 7'b0000100,
      PH_TAG2    = 7'b0001000,
      PH_DSIZE   = 7'b0010000,
      PH_SAMPLES = 7'b0100000,
      PH_DONE    = 7'b1000000
   } phase_type;

   // divider request and answer
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_RIFF   = 3'd1;
   localparam logic [2:0] ERR_WAVE   = 3'd2;
   localparam logic [2:0] ERR_FMT    = 3'd3;
   localparam logic [2:0] ERR_FORMAT = 3'd4;
   localparam logic [2:0] ERR_NODATA = 3'd5;
   localparam logic [2:0] ERR_ZEROCH = 3'd6;

   localparam logic [31:0] TAG_RIFF = 32'h46464952;
   localparam logic [31:0] TAG_WAVE = 32'h45564157;
   localparam logic [31:0] TAG_FMT  = 32'h20746D66;
   localparam logic [31:0] TAG_LIST = 32'h5453494C;
   localparam logic [31:0] TAG_DATA = 32'h61746164;

   localparam logic [5:0] OFF_RIFF  = 6'd3;
   localparam logic [5:0] OFF_WAVE  = 6'd11;
   localparam logic [5:0] OFF_FMT   = 6'd15;
   localparam logic [5:0] OFF_FSIZE = 6'd19;
   localparam logic [5:0] OFF_FORM  = 6'd21;
   localparam logic [5:0] OFF_CHAN  = 6'd23;
   localparam logic [5:0] OFF_RATE  = 6'd27;
   localparam logic [5:0] OFF_BITS  = 6'd35;
   localparam logic [5:0] OFF_CHUNK = 6'd39;
   localparam logic [5:0] OFF_LIMIT = 6'd40;

endpackage

[hw/rtl/wav_pcm_stream_parser.sv]
// wav pcm stream parser top level: header sequencer, sample unpacking
// depends on wps_pkg, wps_divider and the assertion macro header
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/req_stall | wps_pkg::req_item_type
//   rsp_    | out       | rsp_valid/rsp_stall | wps_pkg::rsp_item_type
//
// one byte per cycle while req_stall is low; the data size byte starts the divider, and
// the parser holds req_stall high until the divider returns the frame count
// a byte is taken only while the output register is empty or being drained
// synchronous active-high reset returns to the header tag phase
`timescale 1ns / 1ps
`include "wav_pcm_stream_parser_macros.svh"
module wav_pcm_stream_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  wps_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output wps_pkg::rsp_item_type rsp_item
);

   wps_pkg::phase_type    phase_ff, phase_in;
   logic [5:0]            off_ff, off_in;
   logic [31:0]           acc_ff, acc_in;
   logic [15:0]           chans_ff, chans_in;
   logic                  wide_ff, wide_in;
   logic [31:0]           rate_ff, rate_in;
   logic [31:0]           skip_ff, skip_in;
   logic [31:0]           total_ff, total_in;
   logic [31:0]           fdone_ff, fdone_in;
   logic [15:0]           chidx_ff, chidx_in;
   logic [8:0]            held_ff, held_in;
   logic                  wait_ff, wait_in;
   logic                  ovalid_ff, ovalid_in;
   wps_pkg::rsp_item_type oitem_ff, oitem_in;
   wps_pkg::div_req_type  div_req;
   wps_pkg::div_rsp_type  div_rsp;

   logic        accept;
   logic        out_free;
   logic [31:0] acc_new;
   logic [15:0] half;
   logic [15:0] val;
   logic [15:0] chidx_next;
   logic [31:0] fdone_next;
   logic [31:0] dsize;
   logic        div_end;
   logic        hdr_out;

   wps_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   assign out_free  = !ovalid_ff || !rsp_stall;
   assign req_stall = !out_free || wait_ff;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      phase_in  = phase_ff;
      off_in    = off_ff;
      acc_in    = acc_ff;
      chans_in  = chans_ff;
      wide_in   = wide_ff;
      rate_in   = rate_ff;
      skip_in   = skip_ff;
      total_in  = total_ff;
      fdone_in  = fdone_ff;
      chidx_in  = chidx_ff;
      held_in   = held_ff;
      wait_in   = wait_ff;
      ovalid_in = ovalid_ff && rsp_stall;
      oitem_in  = oitem_ff;
      div_req   = '0;
      acc_new   = '0;
      half      = '0;
      val       = '0;
      chidx_next = '0;
      fdone_next = '0;
      dsize     = '0;

      if (wait_ff && div_rsp.done) begin
         wait_in               = 1'b0;
         total_in              = div_rsp.quotient;
         fdone_in              = 32'd0;
         chidx_in              = 16'd0;
         held_in               = 9'd0;
         ovalid_in             = 1'b1;
         oitem_in              = '0;
         oitem_in.result_kind  = wps_pkg::KIND_ACCEPT;
         oitem_in.out_channels = (chans_ff > 16'd1) ? 2'd2 : 2'd1;
         oitem_in.sample_bits  = wide_ff ? 5'd16 : 5'd8;
         oitem_in.fmt_rate     = rate_ff;
         oitem_in.frame_count  = div_rsp.quotient;
         phase_in = (div_rsp.quotient != 32'd0) ? wps_pkg::PH_SAMPLES
                                                : wps_pkg::PH_DONE;
      end else if (accept) begin
         if (req_item.first_byte) begin
            phase_in = wps_pkg::PH_HEAD;
            off_in   = 6'd0;
            acc_in   = 32'd0;
            chans_in = 16'd0;
            wide_in  = 1'b0;
            rate_in  = 32'd0;
            skip_in  = 32'd0;
            total_in = 32'd0;
            fdone_in = 32'd0;
            chidx_in = 16'd0;
            held_in  = 9'd0;
            acc_new  = {req_item.data_byte, 24'd0};
         end else begin
            acc_new = {req_item.data_byte, acc_ff[31:8]};
         end
         acc_in = acc_new;
         half   = acc_new[31:16];
         case (phase_in)
            wps_pkg::PH_HEAD: begin
               if (off_in < wps_pkg::OFF_LIMIT) off_in = off_in + 6'd1;
               case (off_in - 6'd1)
                  wps_pkg::OFF_RIFF: if (acc_new != wps_pkg::TAG_RIFF) begin
                     ovalid_in = 1'b1;
                     oitem_in = '0;
                     oitem_in.result_kind = wps_pkg::KIND_REJECT;
                     oitem_in.error_code = wps_pkg::ERR_RIFF;
                     phase_in = wps_pkg::PH_DONE;
                  end
                  wps_pkg::OFF_WAVE: if (acc_new != wps_pkg::TAG_WAVE) begin
                     ovalid_in = 1'b1;
                     oitem_in = '0;
                     oitem_in.result_kind = wps_pkg::KIND_REJECT;
                     oitem_in.error_code = wps_pkg::ERR_WAVE;
                     phase_in = wps_pkg::PH_DONE;
                  end
                  wps_pkg::OFF_FMT: if (acc_new != wps_pkg::TAG_FMT) begin
                     ovalid_in = 1'b1;
                     oitem_in = '0;
                     oitem_in.result_kind = wps_pkg::KIND_REJECT;
                     oitem_in.error_code = wps_pkg::ERR_FMT;
                     phase_in = wps_pkg::PH_DONE;
                  end
                  wps_pkg::OFF_FSIZE: skip_in = {31'd0, acc_new != 32'd16};
                  wps_pkg::OFF_FORM: if (half != 16'd1) skip_in = 32'd1;
                  wps_pkg::OFF_CHAN: chans_in = half;
                  wps_pkg::OFF_RATE: rate_in = acc_new;
                  wps_pkg::OFF_BITS: begin
                     if (half != 16'd8 && half != 16'd16) skip_in = 32'd1;
                     wide_in = (half == 16'd16);
                     if (skip_in[0]) begin
                        ovalid_in = 1'b1;
                        oitem_in = '0;
                        oitem_in.result_kind = wps_pkg::KIND_REJECT;
                        oitem_in.error_code = wps_pkg::ERR_FORMAT;
                        phase_in = wps_pkg::PH_DONE;
                     end else begin
                        skip_in = 32'd0;
                        if (chans_in == 16'd0) begin
                           ovalid_in = 1'b1;
                           oitem_in = '0;
                           oitem_in.result_kind = wps_pkg::KIND_REJECT;
                           oitem_in.error_code = wps_pkg::ERR_ZEROCH;
                           phase_in = wps_pkg::PH_DONE;
                        end
                     end
                  end
                  wps_pkg::OFF_CHUNK: begin
                     off_in = 6'd0;
                     if (acc_new == wps_pkg::TAG_LIST) phase_in = wps_pkg::PH_LSIZE;
                     else if (acc_new == wps_pkg::TAG_DATA) phase_in = wps_pkg::PH_DSIZE;
                     else begin
                        ovalid_in = 1'b1;
                        oitem_in = '0;
                        oitem_in.result_kind = wps_pkg::KIND_REJECT;
                        oitem_in.error_code = wps_pkg::ERR_NODATA;
                        phase_in = wps_pkg::PH_DONE;
                     end
                  end
                  default: ;
               endcase
            end
            wps_pkg::PH_LSIZE: begin
               off_in = off_in + 6'd1;
               if (off_in >= 6'd4) begin
                  off_in  = 6'd0;
                  skip_in = acc_new;
                  phase_in = (acc_new != 32'd0) ? wps_pkg::PH_LSKIP : wps_pkg::PH_TAG2;
               end
            end
            wps_pkg::PH_LSKIP: begin
               skip_in = skip_in - 32'd1;
               if (skip_in == 32'd0) begin
                  off_in   = 6'd0;
                  phase_in = wps_pkg::PH_TAG2;
               end
            end
            wps_pkg::PH_TAG2: begin
               off_in = off_in + 6'd1;
               if (off_in >= 6'd4) begin
                  off_in = 6'd0;
                  if (acc_new != wps_pkg::TAG_DATA) begin
                     ovalid_in = 1'b1;
                     oitem_in = '0;
                     oitem_in.result_kind = wps_pkg::KIND_REJECT;
                     oitem_in.error_code = wps_pkg::ERR_NODATA;
                     phase_in = wps_pkg::PH_DONE;
                  end else begin
                     phase_in = wps_pkg::PH_DSIZE;
                  end
               end
            end
            wps_pkg::PH_DSIZE: begin
               off_in = off_in + 6'd1;
               if (off_in >= 6'd4) begin
                  off_in  = 6'd0;
                  dsize   = wide_in ? {1'b0, acc_new[31:1]} : acc_new;
                  div_req.start    = 1'b1;
                  div_req.dividend = dsize;
                  div_req.divisor  = (chans_in != 16'd0) ? chans_in : 16'd1;
                  wait_in = 1'b1;
               end
            end
            wps_pkg::PH_SAMPLES: begin
               if (wide_in && !held_in[8]) begin
                  held_in = {1'b1, req_item.data_byte};
               end else begin
                  val = wide_in ? {req_item.data_byte, held_in[7:0]}
                                : {req_item.data_byte ^ 8'h80, 8'h00};
                  held_in = 9'd0;
                  if (chidx_in == 16'd0 || (chidx_in == 16'd1 && chans_in > 16'd1)) begin
                     ovalid_in = 1'b1;
                     oitem_in = '0;
                     oitem_in.result_kind  = wps_pkg::KIND_SAMPLE;
                     oitem_in.channel      = chidx_in[0];
                     oitem_in.sample_value = val;
                     oitem_in.last_frame   = (fdone_in + 32'd1 == total_in);
                  end
                  chidx_next = chidx_in + 16'd1;
                  if (chidx_next >= chans_in) begin
                     chidx_in   = 16'd0;
                     fdone_next = fdone_in + 32'd1;
                     fdone_in   = fdone_next;
                     if (fdone_next == total_in) phase_in = wps_pkg::PH_DONE;
                  end else begin
                     chidx_in = chidx_next;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      oitem_ff <= oitem_in;
      if (reset) begin
         phase_ff  <= wps_pkg::PH_HEAD;
         off_ff    <= 6'd0;
         acc_ff    <= 32'd0;
         chans_ff  <= 16'd0;
         wide_ff   <= 1'b0;
         rate_ff   <= 32'd0;
         skip_ff   <= 32'd0;
         total_ff  <= 32'd0;
         fdone_ff  <= 32'd0;
         chidx_ff  <= 16'd0;
         held_ff   <= 9'd0;
         wait_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         off_ff    <= off_in;
         acc_ff    <= acc_in;
         chans_ff  <= chans_in;
         wide_ff   <= wide_in;
         rate_ff   <= rate_in;
         skip_ff   <= skip_in;
         total_ff  <= total_in;
         fdone_ff  <= fdone_in;
         chidx_ff  <= chidx_in;
         held_ff   <= held_in;
         wait_ff   <= wait_in;
         ovalid_ff <= ovalid_in;
      end
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_item  = oitem_ff;

   assign div_end = wait_ff && div_rsp.done;
   assign hdr_out = rsp_valid && rsp_item.result_kind == wps_pkg::KIND_ACCEPT;

   `WPS_ASSERT_IMP(a_wait_stalls, clock, reset, wait_ff, req_stall, "input taken during division")
   `WPS_ASSERT_IMP(a_wait_div_busy, clock, reset, wait_ff && !div_rsp.done, div_rsp.busy, "idle divider")
   `WPS_ASSERT_NEXT(a_done_accept, clock, reset, div_end, hdr_out, "header item missing")
   `WPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item), "item moved")

endmodule

[hw/rtl/wps_divider.sv]
// restoring divider, one quotient bit per cycle
// depends on wps_pkg
`timescale 1ns / 1ps
module wps_divider (
   input  logic                clock,
   input  logic                reset,
   input  wps_pkg::div_req_type div_req,
   output wps_pkg::div_rsp_type div_rsp
);

   logic [31:0] quot_ff, quot_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;
   logic [16:0] shifted;

   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      shifted  = {rem_ff, quot_ff[31]};
      trial    = shifted - {1'b0, dsr_ff};
      if (div_req.start) begin
         quot_in  = div_req.dividend;
         rem_in   = 16'd0;
         dsr_in   = div_req.divisor;
         count_in = 6'd32;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (trial[16]) begin
            rem_in  = shifted[15:0];
            quot_in = {quot_ff[30:0], 1'b0};
         end else begin
            rem_in  = trial[15:0];
            quot_in = {quot_ff[30:0], 1'b1};
         end
         count_in = count_ff - 6'd1;
         if (count_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      if (reset) begin
         count_ff <= 6'd0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

[sim/wav_pcm_stream_parser_test.sv]
// self-checking testbench for wav_pcm_stream_parser: streams wav files, whole and truncated,
// good and broken, through the byte channel and scores every result item
// depends on wps_pkg and the wav_pcm_stream_parser rtl
`timescale 1ns / 1ps
module wav_pcm_stream_parser_test;

   class wav_scoreboard;
      wps_pkg::rsp_item_type pending[$];
      int mismatches;
      int n_samples, n_accepts, n_rejects;
      wps_pkg::phase_type phase;
      logic [5:0]  offset;
      logic [31:0] acc, rate, skip, ftotal, fdone;
      logic [15:0] src_ch, ch_idx;
      logic        wide;
      logic [8:0]  held;

      function void restart();
         phase = wps_pkg::PH_HEAD; offset = 0; acc = 0; rate = 0; skip = 0;
         ftotal = 0; fdone = 0; src_ch = 0; ch_idx = 0; wide = 0; held = 0;
      endfunction

      function void push_reject(logic [2:0] code);
         wps_pkg::rsp_item_type r;
         r = '0;
         r.result_kind = wps_pkg::KIND_REJECT;
         r.error_code = code;
         phase = wps_pkg::PH_DONE;
         pending.push_back(r);
      endfunction

      function void note_input(wps_pkg::req_item_type it);
         wps_pkg::rsp_item_type r;
         logic [5:0]   off;
         logic [15:0]  half, value;
         if (it.first_byte) restart();
         acc = {it.data_byte, acc[31:8]};
         half = acc[31:16];
         case (phase)
            wps_pkg::PH_HEAD: begin
               off = offset;
               if (off < wps_pkg::OFF_LIMIT) offset = off + 6'd1;
               case (off)
                  wps_pkg::OFF_RIFF: if (acc != wps_pkg::TAG_RIFF) push_reject(wps_pkg::ERR_RIFF);
                  wps_pkg::OFF_WAVE: if (acc != wps_pkg::TAG_WAVE) push_reject(wps_pkg::ERR_WAVE);
                  wps_pkg::OFF_FMT: if (acc != wps_pkg::TAG_FMT) push_reject(wps_pkg::ERR_FMT);
                  wps_pkg::OFF_FSIZE: skip = (acc != 32'd16) ? 32'd1 : 32'd0;
                  wps_pkg::OFF_FORM: if (half != 16'd1) skip = 32'd1;
                  wps_pkg::OFF_CHAN: src_ch = half;
                  wps_pkg::OFF_RATE: rate = acc;
                  wps_pkg::OFF_BITS: begin
                     if (half != 16'd8 && half != 16'd16) skip = 32'd1;
                     wide = (half == 16'd16);
                     if (skip[0]) push_reject(wps_pkg::ERR_FORMAT);
                     else begin
                        skip = 0;
                        if (src_ch == 0) push_reject(wps_pkg::ERR_ZEROCH);
                     end
                  end
                  wps_pkg::OFF_CHUNK: begin
                     offset = 0;
                     if (acc == wps_pkg::TAG_LIST) phase = wps_pkg::PH_LSIZE;
                     else if (acc == wps_pkg::TAG_DATA) phase = wps_pkg::PH_DSIZE;
                     else push_reject(wps_pkg::ERR_NODATA);
                  end
                  default: ;
               endcase
            end
            wps_pkg::PH_LSIZE: begin
               offset++;
               if (offset >= 4) begin
                  offset = 0;
                  skip = acc;
                  phase = (skip != 0) ? wps_pkg::PH_LSKIP : wps_pkg::PH_TAG2;
               end
            end
            wps_pkg::PH_LSKIP: begin
               skip--;
               if (skip == 0) begin
                  offset = 0;
                  phase = wps_pkg::PH_TAG2;
               end
            end
            wps_pkg::PH_TAG2: begin
               offset++;
               if (offset >= 4) begin
                  offset = 0;
                  if (acc != wps_pkg::TAG_DATA) push_reject(wps_pkg::ERR_NODATA);
                  else phase = wps_pkg::PH_DSIZE;
               end
            end
            wps_pkg::PH_DSIZE: begin
               offset++;
               if (offset >= 4) begin
                  offset = 0;
                  ftotal = (acc >> wide) / ((src_ch != 0) ? {16'd0, src_ch} : 32'd1);
                  fdone = 0; ch_idx = 0; held = 0;
                  r = '0;
                  r.result_kind = wps_pkg::KIND_ACCEPT;
                  r.out_channels = (src_ch > 1) ? 2'd2 : 2'd1;
                  r.sample_bits = wide ? 5'd16 : 5'd8;
                  r.fmt_rate = rate;
                  r.frame_count = ftotal;
                  pending.push_back(r);
                  phase = (ftotal != 0) ? wps_pkg::PH_SAMPLES : wps_pkg::PH_DONE;
               end
            end
            wps_pkg::PH_SAMPLES: begin
               if (wide && !held[8]) held = {1'b1, it.data_byte};
               else begin
                  if (wide) value = {it.data_byte, held[7:0]};
                  else value = {it.data_byte ^ 8'h80, 8'h00};
                  held = 0;
                  if (ch_idx == 0 || (ch_idx == 1 && src_ch > 1)) begin
                     r = '0;
                     r.result_kind = wps_pkg::KIND_SAMPLE;
                     r.channel = ch_idx[0];
                     r.sample_value = value;
                     r.last_frame = (fdone + 32'd1 == ftotal);
                     pending.push_back(r);
                  end
                  ch_idx++;
                  if (ch_idx >= src_ch) begin
                     ch_idx = 0;
                     fdone++;
                     if (fdone == ftotal) phase = wps_pkg::PH_DONE;
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(wps_pkg::rsp_item_type got);
         wps_pkg::rsp_item_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item kind %0d", got.result_kind);
            return;
         end
         want = pending.pop_front();
         if (want.result_kind == wps_pkg::KIND_SAMPLE) n_samples++;
         else if (want.result_kind == wps_pkg::KIND_ACCEPT) n_accepts++;
         else n_rejects++;
         if (got.result_kind !== want.result_kind || got.error_code !== want.error_code ||
             got.channel !== want.channel || got.sample_value !== want.sample_value ||
             got.last_frame !== want.last_frame || got.out_channels !== want.out_channels ||
             got.sample_bits !== want.sample_bits || got.fmt_rate !== want.fmt_rate ||
             got.frame_count !== want.frame_count) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch exp kind %0d err %0d ch %0d val %0d last %0d oc %0d",
                        want.result_kind, want.error_code, want.channel, want.sample_value,
                        want.last_frame, want.out_channels);
               $display("         exp bits %0d rate %h frames %h",
                        want.sample_bits, want.fmt_rate, want.frame_count);
               $display("         got kind %0d err %0d ch %0d val %0d last %0d oc %0d",
                        got.result_kind, got.error_code, got.channel, got.sample_value,
                        got.last_frame, got.out_channels);
               $display("         got bits %0d rate %h frames %h",
                        got.sample_bits, got.fmt_rate, got.frame_count);
            end
         end
      endfunction
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_valid = 0;
   logic                  req_stall;
   wps_pkg::req_item_type req_item = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 0;
   wps_pkg::rsp_item_type rsp_item;

   wav_scoreboard sb = new();
   logic [7:0] file_bytes[$];
   int  bytes_sent = 0;
   int  files_sent = 0;
   bit  quiet_sender = 0;
   bit  sending_done = 0;
   bit  pressure_done = 0;

   wav_pcm_stream_parser dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_item);
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic first);
      int gap;
      gap = quiet_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_item <= '{data_byte: b, first_byte: first};
      do @(posedge clock); while (req_stall);
      sb.note_input('{data_byte: b, first_byte: first});
      bytes_sent++;
   endtask

   task automatic send_file();
      foreach (file_bytes[i]) send_byte(file_bytes[i], i == 0);
      files_sent++;
   endtask

   task automatic put32(input logic [31:0] v);
      for (int i = 0; i < 4; i++) file_bytes.push_back(v[8*i +: 8]);
   endtask

   task automatic put16(input logic [15:0] v);
      file_bytes.push_back(v[7:0]);
      file_bytes.push_back(v[15:8]);
   endtask

   task automatic build_file();
      int fault, n_ch, bps, body;
      logic [15:0] bits;
      logic [31:0] dsize;
      file_bytes.delete();
      fault = ($urandom_range(0, 99) < 70) ? 0 : $urandom_range(1, 9);
      n_ch = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 4) : $urandom_range(1, 2);
      if (fault == 7) n_ch = 0;
      bps = $urandom_range(1, 2);
      bits = 16'(bps * 8);
      if (fault == 6) bits = ($urandom_range(0, 1) != 0) ? 16'd24 : 16'($urandom);
      put32(wps_pkg::TAG_RIFF);
      put32($urandom);
      put32(wps_pkg::TAG_WAVE);
      put32(wps_pkg::TAG_FMT);
      put32((fault == 4) ? 32'd18 : 32'd16);
      put16((fault == 5) ? 16'd3 : 16'd1);
      put16(16'(n_ch));
      put32($urandom);
      put32($urandom);
      put16(16'(n_ch * bps));
      put16(bits);
      if (fault == 8) put32($urandom);
      else if ($urandom_range(0, 2) == 0 || fault == 9) begin
         put32(wps_pkg::TAG_LIST);
         body = $urandom_range(0, 5);
         put32(32'(body));
         repeat (body) file_bytes.push_back(8'($urandom));
         put32((fault == 9) ? wps_pkg::TAG_LIST : wps_pkg::TAG_DATA);
      end else put32(wps_pkg::TAG_DATA);
      case ($urandom_range(0, 9))
         0: dsize = 0;
         1: dsize = 32'hFFFF_FFFF;
         default: dsize = 32'($urandom_range(0, 10) * n_ch * bps + $urandom_range(0, 3));
      endcase
      put32(dsize);
      body = (dsize > 40) ? 40 : int'(dsize);
      body += $urandom_range(0, 3);
      repeat (body) file_bytes.push_back(8'($urandom));
      if (fault >= 1 && fault <= 3) file_bytes[(fault - 1) * 4 + $urandom_range(0, 3)] ^= 8'h20;
      if (fault == 3 && $urandom_range(0, 1) != 0) file_bytes[8] ^= 8'h01;
      if ($urandom_range(0, 14) == 0) file_bytes = file_bytes[0:$urandom_range(1, file_bytes.size() - 1)];
   endtask

   initial begin
      int hold;
      forever begin
         if (sending_done) begin
            rsp_stall <= 0;
            @(posedge clock);
         end else if (bytes_sent > 500 && !pressure_done) begin
            pressure_done = 1;
            rsp_stall <= 1;
            for (hold = 0; hold < 300; hold++) @(posedge clock);
            rsp_stall <= 0;
            repeat (600) @(posedge clock);
         end else begin
            rsp_stall <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1;
            repeat (pick_gap() + 1) @(posedge clock);
         end
      end
   end

   initial begin
      #20ms;
      $display("wav_pcm_stream_parser regression: fail");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // header tag faults, short and direct
      file_bytes = '{8'h52, 8'h49, 8'h46, 8'h47};
      send_file();
      file_bytes = '{8'h52, 8'h49, 8'h46, 8'h46, 8'hFF, 8'h00, 8'hFF, 8'h00,
                     8'h57, 8'h41, 8'h56, 8'h44};
      send_file();
      send_byte(8'hFF, 1);
      send_byte(8'h00, 0);
      while (bytes_sent < 1250) begin
         quiet_sender = ($urandom_range(0, 4) == 0);
         build_file();
         send_file();
         if ($urandom_range(0, 9) == 0) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
      end
      req_valid <= 0;
      sending_done = 1;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("streamed %0d files in %0d bytes", files_sent, bytes_sent);
      $display("scored %0d samples, %0d headers accepted, %0d rejected, %0d mismatches",
               sb.n_samples, sb.n_accepts, sb.n_rejects, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("wav_pcm_stream_parser regression: pass");
      else
         $display("wav_pcm_stream_parser regression: fail");
      $finish;
   end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/wps_pkg.sv
hw/rtl/wps_divider.sv
hw/rtl/wav_pcm_stream_parser.sv
sim/wav_pcm_stream_parser_test.sv
